### rtl/prd_pkg.sv
package prd_pkg;

    localparam int TAG_W     = 8;
    localparam int PRIO_W    = 3;
    localparam int NEED_W    = 4;
    localparam int CAP_W     = 4;
    localparam int CNT_W     = 8;
    localparam int MAX_KINDS = 7;

    localparam int DEF_SLOTS = 16;
    localparam int DEF_KINDS = 7;

    localparam int CFG_IDX_W  = 3;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    localparam logic [PRIO_W-1:0] MAX_PRIO = 3'd5;
    localparam logic [CAP_W-1:0]  CAP_RESET = 4'd1;
    localparam logic [CNT_W-1:0]  CNT_MAX   = 8'hFF;

    localparam logic REQ_SUBMIT   = 1'b0;
    localparam logic REQ_COMPLETE = 1'b1;

    localparam logic RES_DISPATCH = 1'b0;
    localparam logic RES_END      = 1'b1;

    typedef enum logic
    {
        CNT_ADD,
        CNT_SUB
    } cnt_op_t;

endpackage

### rtl/priority_resource_dispatcher.sv
// Priority resource dispatcher. Each input transfer is a submit (tuser 0) or
// a completion (tuser 1). A submit stores the job in the lowest free wait
// slot, a completion frees the lowest running slot with that tag and gives
// back its resource counts. The block then dispatches waiting jobs one at a
// time, highest priority first, then lowest slot, as long as a running slot
// is free and every needed kind is below its cap; each dispatch is one
// output transfer and the step closes with an end transfer (tlast high,
// drop and unknown flags valid). After a request a sweep of the slots finds
// the wait or running slot to use; then each dispatch sweep picks one job,
// and a sweep that finds none closes the step with the end transfer. The
// step length is set by the slot memories, which are swept one entry per
// cycle through a single read port each into one shared kind compare unit.
// The input is not ready during a step; it is ready again while the end
// transfer still waits in the output register. The user must write caps
// through cfg_* only while no step is in progress; the block itself does
// not enforce this. Caps reset to 1.
module priority_resource_dispatcher #(
    parameter int SLOTS = prd_pkg::DEF_SLOTS,
    parameter int KINDS = prd_pkg::DEF_KINDS
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_wen,
    input  logic [prd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [prd_pkg::CAP_W-1:0]       cfg_wdata,

    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: job_id[7:0], priority_req[10:8], need_kind0..6[38:11], pad[39]
    input  logic [prd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // tuser: req_type
    input  logic                            s_axis_tuser,

    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: out_job_id[7:0], out_priority[10:8], dropped[11],
    //        unknown_job[12], pad[15:13]
    output logic [prd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // tuser: result_kind
    output logic                            m_axis_tuser,
    output logic                            m_axis_tlast
);

    import prd_pkg::*;

    localparam int IDX_W    = $clog2(SLOTS);
    localparam int NEEDS_W  = KINDS * NEED_W;
    localparam int NEED_LSB = TAG_W + PRIO_W;
    localparam int WAIT_W   = NEED_LSB + NEEDS_W;
    localparam int RUN_W    = TAG_W + NEEDS_W;
    localparam int CNTS_W   = KINDS * CNT_W;
    localparam int CAPS_W   = KINDS * CAP_W;
    localparam int PAD_W    = OUT_DATA_W - TAG_W - PRIO_W - 2;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_SUBMIT,
        S_COMPLETE,
        S_PICK,
        S_ADMIT,
        S_END
    } state_t;

    // control state
    state_t             state_reg,      state_next;
    logic               issue_reg,      issue_next;
    logic [IDX_W-1:0]   scan_addr_reg,  scan_addr_next;
    logic               chk_valid_reg,  chk_valid_next;
    logic [SLOTS-1:0]   wait_valid_reg, wait_valid_next;
    logic [SLOTS-1:0]   run_valid_reg,  run_valid_next;
    logic [CNTS_W-1:0]  use_cnt_reg,    use_cnt_next;
    logic [CAPS_W-1:0]  cap_reg,        cap_next;
    logic               drop_reg,       drop_next;
    logic               unk_reg,        unk_next;
    logic               best_found_reg, best_found_next;
    logic               free_found_reg, free_found_next;
    logic               out_valid_reg,  out_valid_next;

    // payload
    logic [IDX_W-1:0]   chk_idx_reg;
    logic [WAIT_W-1:0]  in_entry_reg,   in_entry_next;
    logic [IDX_W-1:0]   best_idx_reg,   best_idx_next;
    logic [PRIO_W-1:0]  best_prio_reg,  best_prio_next;
    logic [WAIT_W-1:0]  best_entry_reg, best_entry_next;
    logic [IDX_W-1:0]   free_idx_reg,   free_idx_next;
    logic               out_kind_reg,   out_kind_next;
    logic [TAG_W-1:0]   out_tag_reg,    out_tag_next;
    logic [PRIO_W-1:0]  out_prio_reg,   out_prio_next;
    logic               out_last_reg,   out_last_next;
    logic               out_drop_reg,   out_drop_next;
    logic               out_unk_reg,    out_unk_next;

    // memory ports
    logic               wait_we;
    logic [IDX_W-1:0]   wait_waddr;
    logic [WAIT_W-1:0]  wait_wdata;
    logic [WAIT_W-1:0]  wait_rd;
    logic               run_we;
    logic [IDX_W-1:0]   run_waddr;
    logic [RUN_W-1:0]   run_wdata;
    logic [RUN_W-1:0]   run_rd;

    // shared kind unit
    cnt_op_t            unit_op;
    logic [NEEDS_W-1:0] unit_need;
    logic               unit_fits;
    logic [CNTS_W-1:0]  unit_cnt;

    logic               chk_last;
    logic               out_free;
    logic [PRIO_W-1:0]  in_prio;

    prd_ram #(
        .DEPTH (SLOTS),
        .WIDTH (WAIT_W)
    ) u_wait_ram (
        .clk   (clk),
        .we    (wait_we),
        .waddr (wait_waddr),
        .wdata (wait_wdata),
        .raddr (scan_addr_reg),
        .rdata (wait_rd)
    );

    prd_ram #(
        .DEPTH (SLOTS),
        .WIDTH (RUN_W)
    ) u_run_ram (
        .clk   (clk),
        .we    (run_we),
        .waddr (run_waddr),
        .wdata (run_wdata),
        .raddr (scan_addr_reg),
        .rdata (run_rd)
    );

    prd_kind_unit #(
        .KINDS (KINDS)
    ) u_kind_unit (
        .op      (unit_op),
        .need    (unit_need),
        .use_cnt (use_cnt_reg),
        .cap     (cap_reg),
        .fits    (unit_fits),
        .cnt_new (unit_cnt)
    );

    assign chk_last      = (chk_idx_reg == IDX_W'(SLOTS - 1));
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign in_prio       = (s_axis_tdata[TAG_W +: PRIO_W] > MAX_PRIO) ?
                           MAX_PRIO : s_axis_tdata[TAG_W +: PRIO_W];
    assign s_axis_tready = (state_reg == S_IDLE);

    // Route the unit: returned counts on completion, the chosen job on
    // admission, the entry under test while scanning.
    always_comb
    begin
        unit_op   = CNT_ADD;
        unit_need = wait_rd[NEED_LSB +: NEEDS_W];
        if (state_reg == S_COMPLETE)
        begin
            unit_op   = CNT_SUB;
            unit_need = run_rd[TAG_W +: NEEDS_W];
        end
        else if (state_reg == S_ADMIT)
        begin
            unit_need = best_entry_reg[NEED_LSB +: NEEDS_W];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        issue_next      = issue_reg;
        scan_addr_next  = scan_addr_reg;
        chk_valid_next  = issue_reg;
        wait_valid_next = wait_valid_reg;
        run_valid_next  = run_valid_reg;
        use_cnt_next    = use_cnt_reg;
        cap_next        = cap_reg;
        drop_next       = drop_reg;
        unk_next        = unk_reg;
        best_found_next = best_found_reg;
        free_found_next = free_found_reg;
        out_valid_next  = out_valid_reg;
        in_entry_next   = in_entry_reg;
        best_idx_next   = best_idx_reg;
        best_prio_next  = best_prio_reg;
        best_entry_next = best_entry_reg;
        free_idx_next   = free_idx_reg;
        out_kind_next   = out_kind_reg;
        out_tag_next    = out_tag_reg;
        out_prio_next   = out_prio_reg;
        out_last_next   = out_last_reg;
        out_drop_next   = out_drop_reg;
        out_unk_next    = out_unk_reg;
        wait_we         = 1'b0;
        wait_waddr      = chk_idx_reg;
        wait_wdata      = in_entry_reg;
        run_we          = 1'b0;
        run_waddr       = free_idx_reg;
        run_wdata       = {best_entry_reg[NEED_LSB +: NEEDS_W], best_entry_reg[TAG_W-1:0]};

        // advance the sweep address; the read data is registered and lines up with chk_idx_reg
        if (issue_reg)
        begin
            if (scan_addr_reg == IDX_W'(SLOTS - 1))
            begin
                issue_next     = 1'b0;
                scan_addr_next = '0;
            end
            else
            begin
                scan_addr_next = scan_addr_reg + IDX_W'(1);
            end
        end

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        for (int k = 0; k < KINDS; k++)
        begin
            if (cfg_wen && (cfg_index == CFG_IDX_W'(k)))
            begin
                cap_next[k*CAP_W +: CAP_W] = cfg_wdata;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    in_entry_next  = {s_axis_tdata[NEED_LSB +: NEEDS_W], in_prio,
                                      s_axis_tdata[TAG_W-1:0]};
                    drop_next      = 1'b0;
                    unk_next       = 1'b0;
                    issue_next     = 1'b1;
                    scan_addr_next = '0;
                    state_next     = (s_axis_tuser == REQ_COMPLETE) ? S_COMPLETE : S_SUBMIT;
                end
            end

            S_SUBMIT:
            begin
                if (chk_valid_reg)
                begin
                    if (!wait_valid_reg[chk_idx_reg] || chk_last)
                    begin
                        if (!wait_valid_reg[chk_idx_reg])
                        begin
                            wait_we                      = 1'b1;
                            wait_valid_next[chk_idx_reg] = 1'b1;
                        end
                        else
                        begin
                            drop_next = 1'b1;
                        end
                        // restart the sweep for dispatch
                        issue_next      = 1'b1;
                        scan_addr_next  = '0;
                        chk_valid_next  = 1'b0;
                        best_found_next = 1'b0;
                        free_found_next = 1'b0;
                        state_next      = S_PICK;
                    end
                end
            end

            S_COMPLETE:
            begin
                if (chk_valid_reg)
                begin
                    if (run_valid_reg[chk_idx_reg] &&
                        (run_rd[TAG_W-1:0] == in_entry_reg[TAG_W-1:0]))
                    begin
                        use_cnt_next                = unit_cnt;
                        run_valid_next[chk_idx_reg] = 1'b0;
                        issue_next                  = 1'b1;
                        scan_addr_next              = '0;
                        chk_valid_next              = 1'b0;
                        best_found_next             = 1'b0;
                        free_found_next             = 1'b0;
                        state_next                  = S_PICK;
                    end
                    else if (chk_last)
                    begin
                        unk_next        = 1'b1;
                        issue_next      = 1'b1;
                        scan_addr_next  = '0;
                        chk_valid_next  = 1'b0;
                        best_found_next = 1'b0;
                        free_found_next = 1'b0;
                        state_next      = S_PICK;
                    end
                end
            end

            S_PICK:
            begin
                if (chk_valid_reg)
                begin
                    // lowest free running slot
                    if (!run_valid_reg[chk_idx_reg] && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = chk_idx_reg;
                    end
                    // strictly higher priority wins, so ties keep the lower slot
                    if (wait_valid_reg[chk_idx_reg] && unit_fits &&
                        (!best_found_reg || (wait_rd[TAG_W +: PRIO_W] > best_prio_reg)))
                    begin
                        best_found_next = 1'b1;
                        best_idx_next   = chk_idx_reg;
                        best_prio_next  = wait_rd[TAG_W +: PRIO_W];
                        best_entry_next = wait_rd;
                    end
                    if (chk_last)
                    begin
                        state_next = (free_found_next && best_found_next) ? S_ADMIT : S_END;
                    end
                end
            end

            S_ADMIT:
            begin
                if (out_free)
                begin
                    run_we                        = 1'b1;
                    run_valid_next[free_idx_reg]  = 1'b1;
                    wait_valid_next[best_idx_reg] = 1'b0;
                    use_cnt_next                  = unit_cnt;
                    out_valid_next                = 1'b1;
                    out_kind_next                 = RES_DISPATCH;
                    out_tag_next                  = best_entry_reg[TAG_W-1:0];
                    out_prio_next                 = best_prio_reg;
                    out_last_next                 = 1'b0;
                    out_drop_next                 = 1'b0;
                    out_unk_next                  = 1'b0;
                    // rescan with the new counts
                    issue_next                    = 1'b1;
                    scan_addr_next                = '0;
                    best_found_next               = 1'b0;
                    free_found_next               = 1'b0;
                    state_next                    = S_PICK;
                end
            end

            S_END:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = RES_END;
                    out_tag_next   = '0;
                    out_prio_next  = '0;
                    out_last_next  = 1'b1;
                    out_drop_next  = drop_reg;
                    out_unk_next   = unk_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            issue_reg      <= 1'b0;
            scan_addr_reg  <= '0;
            chk_valid_reg  <= 1'b0;
            wait_valid_reg <= '0;
            run_valid_reg  <= '0;
            use_cnt_reg    <= '0;
            cap_reg        <= {KINDS{CAP_RESET}};
            drop_reg       <= 1'b0;
            unk_reg        <= 1'b0;
            best_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_reg      <= issue_next;
            scan_addr_reg  <= scan_addr_next;
            chk_valid_reg  <= chk_valid_next;
            wait_valid_reg <= wait_valid_next;
            run_valid_reg  <= run_valid_next;
            use_cnt_reg    <= use_cnt_next;
            cap_reg        <= cap_next;
            drop_reg       <= drop_next;
            unk_reg        <= unk_next;
            best_found_reg <= best_found_next;
            free_found_reg <= free_found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg    <= scan_addr_reg;
        in_entry_reg   <= in_entry_next;
        best_idx_reg   <= best_idx_next;
        best_prio_reg  <= best_prio_next;
        best_entry_reg <= best_entry_next;
        free_idx_reg   <= free_idx_next;
        out_kind_reg   <= out_kind_next;
        out_tag_reg    <= out_tag_next;
        out_prio_reg   <= out_prio_next;
        out_last_reg   <= out_last_next;
        out_drop_reg   <= out_drop_next;
        out_unk_reg    <= out_unk_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_unk_reg, out_drop_reg, out_prio_reg, out_tag_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    // a job is never stored over a live wait slot
    a_wait_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        wait_we |-> !wait_valid_reg[wait_waddr])
        else $error("wait slot overwritten while valid");

    // admission never lands on a live running slot
    a_run_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        run_we |-> !run_valid_reg[run_waddr])
        else $error("running slot overwritten while valid");

    // a sweep never leaves a pending check behind when the step ends
    a_idle_no_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!chk_valid_reg && !issue_reg))
        else $error("slot sweep still active in idle");

    // admission only follows a sweep that found a job and a free slot
    a_admit_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADMIT) |-> (best_found_reg && free_found_reg))
        else $error("admission without candidate or free slot");

endmodule

### rtl/prd_ram.sv
module prd_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/prd_kind_unit.sv
module prd_kind_unit #(
    parameter int KINDS = 7
) (
    input  prd_pkg::cnt_op_t                  op,
    input  logic [KINDS*prd_pkg::NEED_W-1:0]  need,
    input  logic [KINDS*prd_pkg::CNT_W-1:0]   use_cnt,
    input  logic [KINDS*prd_pkg::CAP_W-1:0]   cap,
    output logic                              fits,
    output logic [KINDS*prd_pkg::CNT_W-1:0]   cnt_new
);

    import prd_pkg::*;

    // Per-kind cap test and saturating count update, all kinds side by side.
    always_comb
    begin
        logic [NEED_W-1:0] n;
        logic [CNT_W-1:0]  u;
        logic [CAP_W-1:0]  c;
        logic [CNT_W:0]    sum;
        fits    = 1'b1;
        cnt_new = '0;
        for (int k = 0; k < KINDS; k++)
        begin
            n   = need[k*NEED_W +: NEED_W];
            u   = use_cnt[k*CNT_W +: CNT_W];
            c   = cap[k*CAP_W +: CAP_W];
            sum = {1'b0, u} + {{(CNT_W+1-NEED_W){1'b0}}, n};
            if ((n != '0) && (u >= {{(CNT_W-CAP_W){1'b0}}, c}))
            begin
                fits = 1'b0;
            end
            case (op)
                CNT_ADD: cnt_new[k*CNT_W +: CNT_W] = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
                CNT_SUB: cnt_new[k*CNT_W +: CNT_W] =
                    (u > {{(CNT_W-NEED_W){1'b0}}, n}) ?
                    (u - {{(CNT_W-NEED_W){1'b0}}, n}) : '0;
                default: cnt_new[k*CNT_W +: CNT_W] = u;
            endcase
        end
    end

endmodule

### tb/sv/prd_dispatch_checker.sv
`timescale 1ns / 1ps

module prd_dispatch_checker #(
    parameter int SLOTS = prd_pkg::DEF_SLOTS,
    parameter int KINDS = prd_pkg::DEF_KINDS
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_wen,
    input  logic [prd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [prd_pkg::CAP_W-1:0]       cfg_wdata,

    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [prd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic                            s_axis_tuser,

    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [prd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                            m_axis_tuser,
    input  logic                            m_axis_tlast,

    output int                              fail_count,
    output int                              pending
);

    import prd_pkg::*;

    typedef struct packed {
        logic                                valid;
        logic [TAG_W-1:0]                    tag;
        logic [PRIO_W-1:0]                   prio;
        logic [MAX_KINDS-1:0][NEED_W-1:0]    need;
    } job_slot_t;

    typedef struct packed {
        logic               kind;
        logic [TAG_W-1:0]   job_id;
        logic [PRIO_W-1:0]  prio;
        logic               last;
        logic               dropped;
        logic               unknown;
    } dispatch_t;

    job_slot_t        waiting_jobs [SLOTS];
    job_slot_t        running_jobs [SLOTS];
    logic [CNT_W-1:0] in_use       [MAX_KINDS];
    logic [CAP_W-1:0] cap_limit    [MAX_KINDS];
    dispatch_t        expected_dispatches [$];

    task automatic reset_model();
        for (int i = 0; i < SLOTS; i++)
        begin
            waiting_jobs[i] = '0;
            running_jobs[i] = '0;
        end
        for (int k = 0; k < MAX_KINDS; k++)
        begin
            in_use[k]    = '0;
            cap_limit[k] = CAP_RESET;
        end
        expected_dispatches.delete();
        fail_count = 0;
    endtask

    // A job fits when every kind it needs is still below its cap.
    function automatic bit kinds_available(input job_slot_t job);
        for (int k = 0; k < KINDS && k < MAX_KINDS; k++)
            if (job.need[k] != '0 && in_use[k] >= cap_limit[k])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic int first_free_run();
        for (int i = 0; i < SLOTS; i++)
            if (!running_jobs[i].valid)
                return i;
        return -1;
    endfunction

    // Highest priority first, then lowest wait slot.
    function automatic int best_waiting();
        for (int p = MAX_PRIO; p >= 0; p--)
            for (int i = 0; i < SLOTS; i++)
                if (waiting_jobs[i].valid && waiting_jobs[i].prio == p &&
                    kinds_available(waiting_jobs[i]))
                    return i;
        return -1;
    endfunction

    task automatic schedule_request(input logic req,
                                    input logic [IN_DATA_W-1:0] data);
        logic [TAG_W-1:0]  tag;
        logic [PRIO_W-1:0] p;
        logic              drop;
        logic              unk;
        logic [NEED_W-1:0] d;
        int                slot;
        int                r;
        int                w;
        int                sum;
        dispatch_t         res;
        tag  = data[TAG_W-1:0];
        drop = 1'b0;
        unk  = 1'b0;
        slot = -1;
        if (req == REQ_SUBMIT)
        begin
            for (int i = 0; i < SLOTS; i++)
                if (slot < 0 && !waiting_jobs[i].valid)
                    slot = i;
            if (slot < 0)
                drop = 1'b1;
            else
            begin
                p = data[TAG_W +: PRIO_W];
                waiting_jobs[slot].valid = 1'b1;
                waiting_jobs[slot].tag   = tag;
                waiting_jobs[slot].prio  = (p > MAX_PRIO) ? MAX_PRIO : p;
                for (int k = 0; k < MAX_KINDS; k++)
                    waiting_jobs[slot].need[k] = (k < KINDS) ?
                        data[TAG_W + PRIO_W + k * NEED_W +: NEED_W] : '0;
            end
        end
        else
        begin
            for (int i = 0; i < SLOTS; i++)
                if (slot < 0 && running_jobs[i].valid && running_jobs[i].tag == tag)
                    slot = i;
            if (slot < 0)
                unk = 1'b1;
            else
            begin
                // give back the counts, never below zero
                for (int k = 0; k < MAX_KINDS; k++)
                begin
                    d = running_jobs[slot].need[k];
                    in_use[k] = (in_use[k] > d) ? in_use[k] - d : '0;
                end
                running_jobs[slot].valid = 1'b0;
            end
        end

        while (1)
        begin
            r = first_free_run();
            if (r < 0)
                break;
            w = best_waiting();
            if (w < 0)
                break;
            running_jobs[r] = waiting_jobs[w];
            for (int k = 0; k < MAX_KINDS; k++)
            begin
                sum = int'(in_use[k]) + int'(waiting_jobs[w].need[k]);
                in_use[k] = (sum > int'(CNT_MAX)) ? CNT_MAX : CNT_W'(sum);
            end
            waiting_jobs[w].valid = 1'b0;
            res         = '0;
            res.kind    = RES_DISPATCH;
            res.job_id  = waiting_jobs[w].tag;
            res.prio    = waiting_jobs[w].prio;
            expected_dispatches.push_back(res);
        end

        res         = '0;
        res.kind    = RES_END;
        res.last    = 1'b1;
        res.dropped = drop;
        res.unknown = unk;
        expected_dispatches.push_back(res);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result();
        dispatch_t want;
        if (expected_dispatches.size() == 0)
        begin
            $error("unexpected result transfer: tdata %h tuser %b tlast %b",
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
            fail_count++;
        end
        else
        begin
            want = expected_dispatches.pop_front();
            check_field("result_kind", want.kind, m_axis_tuser);
            check_field("out_job_id", want.job_id, m_axis_tdata[TAG_W-1:0]);
            check_field("out_priority", want.prio, m_axis_tdata[TAG_W +: PRIO_W]);
            check_field("last", want.last, m_axis_tlast);
            check_field("dropped", want.dropped, m_axis_tdata[TAG_W + PRIO_W]);
            check_field("unknown_job", want.unknown, m_axis_tdata[TAG_W + PRIO_W + 1]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            reset_model();
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (cfg_wen && cfg_index < MAX_KINDS)
                cap_limit[cfg_index] = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                schedule_request(s_axis_tuser, s_axis_tdata);
        end
        pending = expected_dispatches.size();
    end

endmodule

### tb/sv/priority_resource_dispatcher_tb.sv
`timescale 1ns / 1ps

module priority_resource_dispatcher_tb;

    import prd_pkg::*;

    // Stream and config signals driven on the falling edge
    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wen;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CAP_W-1:0]       cfg_wdata;

    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // tdata: job_id[7:0], priority_req[10:8], need_kind0..6[38:11], pad[39]
    logic [IN_DATA_W-1:0]   s_axis_tdata;
    // tuser: req_type
    logic                   s_axis_tuser;

    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // tdata: out_job_id[7:0], out_priority[10:8], dropped[11], unknown_job[12], pad[15:13]
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    // tuser: result_kind
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;

    int                     fail_count;
    int                     pending;

    // Idle knobs, percent of cycles
    int                     send_idle_pct = 0;
    int                     stall_pct = 0;

    // Tags submitted so far; completions mostly pick from here
    logic [TAG_W-1:0]       live_tags [$];

    priority_resource_dispatcher #(
        .SLOTS  (DEF_SLOTS),
        .KINDS  (DEF_KINDS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wen        (cfg_wen),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast)
    );

    prd_dispatch_checker #(
        .SLOTS  (DEF_SLOTS),
        .KINDS  (DEF_KINDS)
    ) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wen        (cfg_wen),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: far beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("priority_resource_dispatcher verification failed");
        $finish;
    end

    // Result side: stall at the phase rate.
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Drive one request and hold it until the transfer completes. Valid stays
    // high into the next call when no idle cycle is drawn.
    task automatic send_request(input logic req, input logic [TAG_W-1:0] tag,
                                input logic [PRIO_W-1:0] prio,
                                input logic [MAX_KINDS-1:0][NEED_W-1:0] needs);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {1'b0, needs, prio, tag};
        if (req == REQ_SUBMIT)
            live_tags.push_back(tag);
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Drop valid, then hold until every expected result has arrived and the
    // block has had time to settle.
    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (2 * (DEF_SLOTS + 2))
            @(negedge clk);
    endtask

    // Write all caps, plus the unused index, while the block is idle.
    task automatic set_caps(input logic [MAX_KINDS-1:0][CAP_W-1:0] caps);
        logic [CFG_IDX_W-1:0] idx;
        wait_idle();
        for (int k = 0; k < MAX_KINDS; k++)
        begin
            idx       = CFG_IDX_W'(k);
            cfg_wen   <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= caps[k];
            @(negedge clk);
        end
        idx       = CFG_IDX_W'(MAX_KINDS);
        cfg_index <= idx;
        cfg_wdata <= CAP_W'($urandom);
        @(negedge clk);
        cfg_wen   <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly well-formed traffic: submits with sparse needs from a small tag
    // pool, completions of tags already submitted; the rest is random tags.
    task automatic random_request(input int submit_pct);
        logic [MAX_KINDS-1:0][NEED_W-1:0] needs;
        logic [TAG_W-1:0]                 tag;
        int                               pick;
        bit                               no_needs;
        if ($urandom_range(99) < submit_pct)
        begin
            no_needs = ($urandom_range(3) == 0);
            for (int k = 0; k < MAX_KINDS; k++)
                needs[k] = (no_needs || $urandom_range(1) == 0) ? '0 :
                           NEED_W'($urandom_range(15));
            tag = ($urandom_range(3) == 0) ? TAG_W'($urandom) : TAG_W'($urandom_range(31));
            send_request(REQ_SUBMIT, tag, PRIO_W'($urandom_range(7)), needs);
        end
        else
        begin
            for (int k = 0; k < MAX_KINDS; k++)
                needs[k] = NEED_W'($urandom);
            if (live_tags.size() > 0 && $urandom_range(3) != 0)
            begin
                pick = $urandom_range(live_tags.size() - 1);
                tag  = live_tags[pick];
                live_tags.delete(pick);
            end
            else
                tag = TAG_W'($urandom);
            send_request(REQ_COMPLETE, tag, PRIO_W'($urandom), needs);
        end
    endtask

    initial
    begin
        logic [MAX_KINDS-1:0][CAP_W-1:0] caps;
        logic [MAX_KINDS-1:0][NEED_W-1:0] one_need;

        rst_n         = 1'b0;
        cfg_wen       = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_SUBMIT;

        repeat (12)
            @(negedge clk);
        rst_n <= 1'b1;
        repeat (2)
            @(negedge clk);

        // Directed part, caps at reset value 1.
        // Job with no needs goes straight out; tag and priority extremes.
        send_request(REQ_SUBMIT, 8'h00, 3'd0, '0);
        // Priority 7 clamps to 5; all needs at maximum still fit at zero use.
        send_request(REQ_SUBMIT, 8'hFF, 3'd7, {MAX_KINDS{4'hF}});
        // These two block behind the full-use job; priority 6 clamps too.
        one_need    = '0;
        one_need[0] = 4'd1;
        send_request(REQ_SUBMIT, 8'h11, 3'd6, one_need);
        one_need    = '0;
        one_need[1] = 4'd1;
        send_request(REQ_SUBMIT, 8'h12, 3'd3, one_need);
        // Completion releases the counts and both waiting jobs dispatch.
        send_request(REQ_COMPLETE, 8'hFF, 3'd0, '0);
        // Tag that matches no running slot.
        send_request(REQ_COMPLETE, 8'h77, 3'd0, '0);
        send_request(REQ_COMPLETE, 8'h00, 3'd0, '0);
        send_request(REQ_COMPLETE, 8'h11, 3'd0, '0);
        send_request(REQ_COMPLETE, 8'h12, 3'd0, '0);

        // Zero cap on kind 0: a job needing it stays parked.
        caps    = {MAX_KINDS{4'd1}};
        caps[0] = 4'd0;
        set_caps(caps);
        one_need    = '0;
        one_need[0] = 4'd2;
        send_request(REQ_SUBMIT, 8'h21, 3'd2, one_need);
        send_request(REQ_SUBMIT, 8'h22, 3'd1, '0);
        // Raise the cap; the parked job leaves on the next request.
        caps[0] = 4'd15;
        set_caps(caps);
        one_need    = '0;
        one_need[6] = 4'd3;
        send_request(REQ_SUBMIT, 8'h23, 3'd0, one_need);
        // Duplicate tags: each completion frees the lowest matching slot.
        send_request(REQ_SUBMIT, 8'h33, 3'd4, '0);
        send_request(REQ_SUBMIT, 8'h33, 3'd4, '0);
        send_request(REQ_COMPLETE, 8'h33, 3'd0, '0);
        send_request(REQ_COMPLETE, 8'h33, 3'd0, '0);
        send_request(REQ_COMPLETE, 8'h33, 3'd0, '0);
        send_request(REQ_COMPLETE, 8'h21, 3'd0, '0);
        send_request(REQ_COMPLETE, 8'h22, 3'd0, '0);
        send_request(REQ_COMPLETE, 8'h23, 3'd0, '0);
        live_tags.delete();

        // Phase 0: caps at maximum, no idling, submit-heavy to fill run slots.
        set_caps({MAX_KINDS{4'd15}});
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (92)
            random_request(65);

        // Phase 1: random caps with one kind shut, sender mostly idle.
        for (int k = 0; k < MAX_KINDS; k++)
            caps[k] = CAP_W'($urandom_range(15));
        caps[6] = 4'd0;
        set_caps(caps);
        send_idle_pct = 81;
        stall_pct     = 0;
        repeat (92)
            random_request(55);

        // Phase 2: tight caps, receiver mostly stalled.
        caps    = {MAX_KINDS{4'd1}};
        caps[3] = 4'd0;
        set_caps(caps);
        send_idle_pct = 0;
        stall_pct     = 81;
        repeat (92)
            random_request(50);

        // Phase 3: small random caps, light idling on both sides.
        for (int k = 0; k < MAX_KINDS; k++)
            caps[k] = CAP_W'($urandom_range(3));
        set_caps(caps);
        send_idle_pct = 22;
        stall_pct     = 22;
        repeat (94)
            random_request(60);

        wait_idle();
        if (fail_count == 0 && pending == 0)
            $display("priority_resource_dispatcher verification clean");
        else
            $display("priority_resource_dispatcher verification failed");
        $finish;
    end

endmodule
